>>> src/sphk_pkg.sv
// sphk_pkg: shared widths, payload structs and register indexes for the
// cubic spline kernel core. No dependencies.
package sphk_pkg;

  // fixed-point format of positions, lengths and results
  localparam int FRAC_BITS = 16;

  // datapath widths
  localparam int POS_W      = 20;  // input coordinate
  localparam int AD_W       = 20;  // magnitude of a coordinate difference
  localparam int SQ_W       = 40;  // square of one difference
  localparam int R2_W       = 42;  // squared distance
  localparam int R_W        = 21;  // distance
  localparam int SQ_REM_W   = 24;  // square root partial remainder
  localparam int H_W        = 18;  // smoothing length
  localparam int INV_H_W    = 32;
  localparam int NORM_W     = 32;
  localparam int GCOEF_W    = 39;
  localparam int Q_W        = 37;  // q = r / h
  localparam int LA_W       = 23;  // |3r - 4h|
  localparam int DA_W       = 21;  // |r - 2h|
  localparam int T2_W       = 18;  // 2 - q
  localparam int T1_W       = 17;  // 1 - q
  localparam int U2_W       = 19;
  localparam int U1_W       = 17;
  localparam int C2_W       = 20;  // (2 - q)^3
  localparam int C1_W       = 17;  // (1 - q)^3
  localparam int P_W        = 26;  // (r - 2h)^2
  localparam int MI_W       = 27;  // inner gradient magnitude before scaling
  localparam int N_W        = 46;  // outer dividend, also quotient width
  localparam int POLY_W     = 20;
  localparam int WT_W       = 36;  // weight before padding to the port
  localparam int X_W        = 48;  // 3 * magnitude
  localparam int G_W        = 40;  // scaled magnitude, clamped at 2^39
  localparam int WEIGHT_W   = 39;
  localparam int GRAD_W     = 40;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 39;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SMOOTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_COEF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_COEF  = 2'd3;

  // one particle pair
  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
  } in_item_t;

  // kernel weight and gradient
  typedef struct packed {
    logic        [WEIGHT_W-1:0] weight;
    logic signed [GRAD_W-1:0]   grad_x;
    logic signed [GRAD_W-1:0]   grad_y;
    logic signed [GRAD_W-1:0]   grad_z;
  } out_item_t;

endpackage

>>> src/sphk_sqrt_cell.sv
// sphk_sqrt_cell: one stage of the digit-by-digit square root chain,
// settles one root bit per cycle while en is high. Depends on sphk_pkg.
module sphk_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [sphk_pkg::R2_W-1:0]     rad_i,
  input  logic [sphk_pkg::SQ_REM_W-1:0] rem_i,
  input  logic [sphk_pkg::R_W-1:0]      root_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          vld_o,
  output logic [sphk_pkg::R2_W-1:0]     rad_o,
  output logic [sphk_pkg::SQ_REM_W-1:0] rem_o,
  output logic [sphk_pkg::R_W-1:0]      root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import sphk_pkg::*;

  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;
  logic [SQ_REM_W-1:0] rem_nxt;
  logic                ge;
  logic                vld_r;
  logic [R2_W-1:0]     rad_r;
  logic [SQ_REM_W-1:0] rem_r;
  logic [R_W-1:0]      root_r;
  logic [SIDE_W-1:0]   side_r;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {rem_i[SQ_REM_W-3:0], rad_i[R2_W-1 -: 2]};
    trial   = {{(SQ_REM_W-R_W-2){1'b0}}, root_i, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload toward the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[R2_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_i[R_W-2:0], ge};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

>>> src/sphk_div_cell.sv
// sphk_div_cell: one stage of the restoring divider chain, one quotient
// bit per cycle while en is high, for each of the three axes. Depends on sphk_pkg.
module sphk_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic [2:0][sphk_pkg::N_W-1:0]    num_i,
  input  logic [2:0][sphk_pkg::R_W-1:0]    rem_i,
  input  logic [2:0][sphk_pkg::N_W-1:0]    quo_i,
  input  logic [sphk_pkg::R_W-1:0]         dvs_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             vld_o,
  output logic [2:0][sphk_pkg::N_W-1:0]    num_o,
  output logic [2:0][sphk_pkg::R_W-1:0]    rem_o,
  output logic [2:0][sphk_pkg::N_W-1:0]    quo_o,
  output logic [sphk_pkg::R_W-1:0]         dvs_o,
  output logic [SIDE_W-1:0]                side_o
);
  import sphk_pkg::*;

  logic [2:0][R_W:0]   rem_sh;
  logic [2:0]          ge;
  logic [2:0][R_W-1:0] rem_nxt;
  logic                vld_r;
  logic [2:0][N_W-1:0] num_r;
  logic [2:0][R_W-1:0] rem_r;
  logic [2:0][N_W-1:0] quo_r;
  logic [R_W-1:0]      dvs_r;
  logic [SIDE_W-1:0]   side_r;

  // shift in the next dividend bit and subtract where it fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k]  = {rem_i[k], num_i[k][N_W-1]};
      ge[k]      = (rem_sh[k] >= {1'b0, dvs_i});
      rem_nxt[k] = ge[k] ? R_W'(rem_sh[k] - {1'b0, dvs_i}) : rem_sh[k][R_W-1:0];
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload toward the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= {num_i[k][N_W-2:0], 1'b0};
        quo_r[k] <= {quo_i[k][N_W-2:0], ge[k]};
      end
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign num_o  = num_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign dvs_o  = dvs_r;
  assign side_o = side_r;

endmodule

>>> src/sph_cubic_spline_kernel_core.sv
// sph_cubic_spline_kernel_core: 3D cubic spline kernel weight and gradient
// for one particle pair per cycle unless stalled. Depends on sphk_pkg,
// sphk_sqrt_cell, sphk_div_cell.
//
// Usage:
//   in_item carries the two positions; an item is taken at a clock edge with
//   in_valid high and in_stall low. out_item carries the weight and the three
//   gradient components; it is taken with out_valid high and out_stall low.
//   cfg_index / cfg_data write h, 1/h, C and C/h^3; cfg_ready is always high.
//   Write configuration only while no item is in flight.
// Pipeline: a 21-cell square root chain (one root bit per cell) and a
//   46-cell divider chain (one quotient bit per cell), plus nine arithmetic
//   stages and the output register.
// Throughput: one item per cycle while no stall freezes the pipeline; every stage of both chains holds an item.
// Stall: while the output register holds an item and out_stall is high, the
//   whole pipeline freezes and in_stall is raised; the held item is not lost.
// Reset: rst_n (synchronous) empties the pipeline and loads the default
//   configuration registers.
module sph_cubic_spline_kernel_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sphk_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sphk_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sphk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sphk_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sphk_pkg::*;

  localparam int SQ_CELLS   = R_W;
  localparam int DV_CELLS   = N_W;
  localparam int SQ_SIDE_W  = 3 + 3 * AD_W;
  localparam int DV_SIDE_W  = POLY_W + 3 + 3 + 3 * MI_W;
  localparam int PROD_W     = 87;
  localparam int XH_W       = X_W / 2;
  localparam int GL_W       = 20;
  localparam int GH_W       = GCOEF_W - GL_W;
  localparam logic [T2_W-1:0] TWO_FX = T2_W'(2 << FRAC_BITS);
  localparam logic [T1_W-1:0] ONE_FX = T1_W'(1 << FRAC_BITS);
  localparam logic [G_W-1:0]  G_SAT  = G_W'(1) << (G_W - 1);
  localparam logic [G_W-1:0]  G_POS  = G_SAT - G_W'(1);

  // configuration registers
  logic [H_W-1:0]     h_r;
  logic [INV_H_W-1:0] inv_h_r;
  logic [NORM_W-1:0]  norm_r;
  logic [GCOEF_W-1:0] gcoef_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= H_W'(6554);
      inv_h_r <= INV_H_W'(655360);
      norm_r  <= NORM_W'(5215189);
      gcoef_r <= GCOEF_W'(64'd5215189000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SMOOTH_LEN: h_r     <= cfg_data[H_W-1:0];
        CFG_INV_SMOOTH: inv_h_r <= cfg_data[INV_H_W-1:0];
        CFG_NORM_COEF:  norm_r  <= cfg_data[NORM_W-1:0];
        CFG_GRAD_COEF:  gcoef_r <= cfg_data[GCOEF_W-1:0];
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 0: coordinate differences
  logic                  v0_r;
  logic [2:0][AD_W:0]    d_nxt;
  logic [2:0][AD_W:0]    d0_r;

  always_comb begin
    d_nxt[0] = {in_item.pos_a_x[POS_W-1], in_item.pos_a_x}
             - {in_item.pos_b_x[POS_W-1], in_item.pos_b_x};
    d_nxt[1] = {in_item.pos_a_y[POS_W-1], in_item.pos_a_y}
             - {in_item.pos_b_y[POS_W-1], in_item.pos_b_y};
    d_nxt[2] = {in_item.pos_a_z[POS_W-1], in_item.pos_a_z}
             - {in_item.pos_b_z[POS_W-1], in_item.pos_b_z};
  end

  // stage 1: magnitudes and squares
  logic [2:0][AD_W:0]    ad1_nxt;
  logic                  v1_r;
  logic [2:0][AD_W-1:0]  ad1_r;
  logic [2:0]            dneg1_r;
  logic [2:0][SQ_W-1:0]  sq1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ad1_nxt[k] = d0_r[k][AD_W] ? (AD_W+1)'(-d0_r[k]) : d0_r[k];
    end
  end

  // stage 2: squared distance
  logic                  v2_r;
  logic [R2_W-1:0]       r2_r;
  logic [2:0][AD_W-1:0]  ad2_r;
  logic [2:0]            dneg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= d_nxt;
      for (int k = 0; k < 3; k++) begin
        ad1_r[k]   <= ad1_nxt[k][AD_W-1:0];
        dneg1_r[k] <= d0_r[k][AD_W];
        sq1_r[k]   <= SQ_W'(ad1_nxt[k][AD_W-1:0]) * SQ_W'(ad1_nxt[k][AD_W-1:0]);
      end
      r2_r    <= R2_W'(sq1_r[0]) + R2_W'(sq1_r[1]) + R2_W'(sq1_r[2]);
      ad2_r   <= ad1_r;
      dneg2_r <= dneg1_r;
    end
  end

  // square root chain
  logic [SQ_CELLS:0]                 sq_vld;
  logic [SQ_CELLS:0][R2_W-1:0]       sq_rad;
  logic [SQ_CELLS:0][SQ_REM_W-1:0]   sq_rem;
  logic [SQ_CELLS:0][R_W-1:0]        sq_root;
  logic [SQ_CELLS:0][SQ_SIDE_W-1:0]  sq_side;

  assign sq_vld[0]  = v2_r;
  assign sq_rad[0]  = r2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {dneg2_r, ad2_r};

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    sphk_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // stage q: q = r / h, |3r - 4h| and |r - 2h|
  logic [R_W-1:0]            r_s;
  logic [2:0][AD_W-1:0]      ad_s;
  logic [2:0]                dneg_s;
  logic [R_W+INV_H_W-1:0]    qprod;
  logic [LA_W-1:0]           r3;
  logic [LA_W-1:0]           h4;
  logic [DA_W-1:0]           h2;
  logic                      lin_neg;
  logic [LA_W-1:0]           la_nxt;
  logic [DA_W-1:0]           da_nxt;

  always_comb begin
    r_s     = sq_root[SQ_CELLS];
    {dneg_s, ad_s} = sq_side[SQ_CELLS];
    qprod   = (R_W+INV_H_W)'(r_s) * (R_W+INV_H_W)'(inv_h_r);
    r3      = LA_W'(r_s) + LA_W'({r_s, 1'b0});
    h4      = LA_W'({h_r, 2'b00});
    h2      = DA_W'({h_r, 1'b0});
    lin_neg = (r3 < h4);
    la_nxt  = lin_neg ? (h4 - r3) : (r3 - h4);
    da_nxt  = (r_s >= h2) ? (r_s - h2) : (h2 - r_s);
  end

  logic                  vq_r;
  logic [Q_W-1:0]        q_r;
  logic [LA_W-1:0]       la_r;
  logic                  linneg_q_r;
  logic [DA_W-1:0]       da_r;
  logic [R_W-1:0]        r_q_r;
  logic [2:0][AD_W-1:0]  ad_q_r;
  logic [2:0]            dneg_q_r;

  // stage c1: branch, squares of 2-q, 1-q, r-2h; inner magnitude
  logic                  c1_far;
  logic                  c1_inner;
  logic [T2_W-1:0]       t2_nxt;
  logic [T1_W-1:0]       t1_nxt;
  logic [2*T2_W-1:0]     t2sq;
  logic [2*T1_W-1:0]     t1sq;
  logic [2*DA_W-1:0]     dasq;
  logic [2:0][AD_W+LA_W-1:0] miprod;

  always_comb begin
    c1_far   = |q_r[Q_W-1:FRAC_BITS+1];
    c1_inner = ~|q_r[Q_W-1:FRAC_BITS];
    t2_nxt   = TWO_FX - q_r[T2_W-1:0];
    t1_nxt   = ONE_FX - q_r[T1_W-1:0];
    t2sq     = (2*T2_W)'(t2_nxt) * (2*T2_W)'(t2_nxt);
    t1sq     = (2*T1_W)'(t1_nxt) * (2*T1_W)'(t1_nxt);
    dasq     = (2*DA_W)'(da_r) * (2*DA_W)'(da_r);
    for (int k = 0; k < 3; k++) begin
      miprod[k] = (AD_W+LA_W)'(ad_q_r[k]) * (AD_W+LA_W)'(la_r);
    end
  end

  logic                  vc1_r;
  logic                  far1_r;
  logic                  inner1_r;
  logic [T2_W-1:0]       t2_r;
  logic [T1_W-1:0]       t1_r;
  logic [U2_W-1:0]       u2_r;
  logic [U1_W-1:0]       u1_r;
  logic [P_W-1:0]        p_r;
  logic [2:0][MI_W-1:0]  mi1_r;
  logic [R_W-1:0]        r1_r;
  logic [2:0][AD_W-1:0]  ad1c_r;
  logic [2:0]            dneg1c_r;
  logic                  linneg1_r;

  // stage c2: cubes and outer dividends
  logic [U2_W+T2_W-1:0]  c2prod;
  logic [U1_W+T1_W-1:0]  c1prod;

  always_comb begin
    c2prod = (U2_W+T2_W)'(u2_r) * (U2_W+T2_W)'(t2_r);
    c1prod = (U1_W+T1_W)'(u1_r) * (U1_W+T1_W)'(t1_r);
  end

  logic                  vc2_r;
  logic                  far2_r;
  logic                  inner2_r;
  logic [C2_W-1:0]       cb2_r;
  logic [C1_W-1:0]       cb1_r;
  logic [2:0][N_W-1:0]   n_r;
  logic [R_W-1:0]        r2d_r;
  logic [2:0][MI_W-1:0]  mi2_r;
  logic [2:0]            dneg2c_r;
  logic                  linneg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r  <= 1'b0;
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
    end else if (en) begin
      vq_r  <= sq_vld[SQ_CELLS];
      vc1_r <= vq_r;
      vc2_r <= vc1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r        <= qprod[FRAC_BITS +: Q_W];
      la_r       <= la_nxt;
      linneg_q_r <= lin_neg;
      da_r       <= da_nxt;
      r_q_r      <= r_s;
      ad_q_r     <= ad_s;
      dneg_q_r   <= dneg_s;

      far1_r     <= c1_far;
      inner1_r   <= c1_inner;
      t2_r       <= t2_nxt;
      t1_r       <= t1_nxt;
      u2_r       <= t2sq[FRAC_BITS +: U2_W];
      u1_r       <= t1sq[FRAC_BITS +: U1_W];
      p_r        <= dasq[FRAC_BITS +: P_W];
      for (int k = 0; k < 3; k++) begin
        mi1_r[k] <= miprod[k][FRAC_BITS +: MI_W];
      end
      r1_r       <= r_q_r;
      ad1c_r     <= ad_q_r;
      dneg1c_r   <= dneg_q_r;
      linneg1_r  <= linneg_q_r;

      far2_r     <= far1_r;
      inner2_r   <= inner1_r;
      cb2_r      <= c2prod[FRAC_BITS +: C2_W];
      cb1_r      <= c1prod[FRAC_BITS +: C1_W];
      for (int k = 0; k < 3; k++) begin
        n_r[k]   <= N_W'(ad1c_r[k]) * N_W'(p_r);
      end
      r2d_r      <= r1_r;
      mi2_r      <= mi1_r;
      dneg2c_r   <= dneg1c_r;
      linneg2_r  <= linneg1_r;
    end
  end

  // spline polynomial, rides along the divider chain
  logic [POLY_W+1:0] poly_full;

  always_comb begin
    poly_full = (POLY_W+2)'(cb2_r)
              - (inner2_r ? (POLY_W+2)'({cb1_r, 2'b00}) : (POLY_W+2)'(0));
  end

  // divider chain for the outer gradient
  logic [DV_CELLS:0]                 dv_vld;
  logic [DV_CELLS:0][2:0][N_W-1:0]   dv_num;
  logic [DV_CELLS:0][2:0][R_W-1:0]   dv_rem;
  logic [DV_CELLS:0][2:0][N_W-1:0]   dv_quo;
  logic [DV_CELLS:0][R_W-1:0]        dv_dvs;
  logic [DV_CELLS:0][DV_SIDE_W-1:0]  dv_side;

  assign dv_vld[0]  = vc2_r;
  assign dv_num[0]  = n_r;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_dvs[0]  = r2d_r;
  assign dv_side[0] = {poly_full[POLY_W-1:0], far2_r, inner2_r, linneg2_r,
                       dneg2c_r, mi2_r};

  for (genvar i = 0; i < DV_CELLS; i++) begin : g_div
    sphk_div_cell #(.SIDE_W(DV_SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[i]),
      .num_i  (dv_num[i]),
      .rem_i  (dv_rem[i]),
      .quo_i  (dv_quo[i]),
      .dvs_i  (dv_dvs[i]),
      .side_i (dv_side[i]),
      .vld_o  (dv_vld[i+1]),
      .num_o  (dv_num[i+1]),
      .rem_o  (dv_rem[i+1]),
      .quo_o  (dv_quo[i+1]),
      .dvs_o  (dv_dvs[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // stage g0: weight product and 3 * magnitude
  logic [POLY_W-1:0]         poly_e;
  logic                      far_e;
  logic                      inner_e;
  logic                      linneg_e;
  logic [2:0]                dneg_e;
  logic [2:0][MI_W-1:0]      mi_e;
  logic [NORM_W+POLY_W-1:0]  wprod;
  logic [2:0][N_W-1:0]       xsrc;
  logic [2:0]                neg_nxt;

  always_comb begin
    {poly_e, far_e, inner_e, linneg_e, dneg_e, mi_e} = dv_side[DV_CELLS];
    wprod = (NORM_W+POLY_W)'(norm_r) * (NORM_W+POLY_W)'(poly_e);
    for (int k = 0; k < 3; k++) begin
      xsrc[k]    = inner_e ? N_W'(mi_e[k]) : dv_quo[DV_CELLS][k];
      neg_nxt[k] = inner_e ? (dneg_e[k] ^ linneg_e) : ~dneg_e[k];
    end
  end

  logic                  vg0_r;
  logic                  farg0_r;
  logic [WT_W-1:0]       wt0_r;
  logic [2:0][X_W-1:0]   x_r;
  logic [2:0]            neg0_r;

  // stage g1: partial products of C/h^3 times 3 * magnitude
  logic                  vg1_r;
  logic                  farg1_r;
  logic [WT_W-1:0]       wt1_r;
  logic [2:0]            neg1_r;
  logic [2:0][GL_W+XH_W-1:0] pp_ll_r;
  logic [2:0][GL_W+XH_W-1:0] pp_lh_r;
  logic [2:0][GH_W+XH_W-1:0] pp_hl_r;
  logic [2:0][GH_W+XH_W-1:0] pp_hh_r;

  // stage g2: sum, scale and clamp
  logic [2:0][PROD_W-1:0]        prod;
  logic [2:0][PROD_W-FRAC_BITS-1:0] prod_sh;
  logic [2:0][G_W-1:0]           g_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(pp_ll_r[k])
              + (PROD_W'(pp_lh_r[k]) << XH_W)
              + (PROD_W'(pp_hl_r[k]) << GL_W)
              + (PROD_W'(pp_hh_r[k]) << (GL_W + XH_W));
      prod_sh[k] = prod[k][PROD_W-1:FRAC_BITS];
      g_nxt[k]   = (|prod_sh[k][PROD_W-FRAC_BITS-1:G_W-1]) ? G_SAT
                 : {1'b0, prod_sh[k][G_W-2:0]};
    end
  end

  logic                  vg2_r;
  logic                  farg2_r;
  logic [WT_W-1:0]       wt2_r;
  logic [2:0]            neg2_r;
  logic [2:0][G_W-1:0]   g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg0_r <= 1'b0;
      vg1_r <= 1'b0;
      vg2_r <= 1'b0;
    end else if (en) begin
      vg0_r <= dv_vld[DV_CELLS];
      vg1_r <= vg0_r;
      vg2_r <= vg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      farg0_r <= far_e;
      wt0_r   <= wprod[FRAC_BITS +: WT_W];
      neg0_r  <= neg_nxt;
      for (int k = 0; k < 3; k++) begin
        x_r[k] <= X_W'(xsrc[k]) + X_W'({xsrc[k], 1'b0});
      end

      farg1_r <= farg0_r;
      wt1_r   <= wt0_r;
      neg1_r  <= neg0_r;
      for (int k = 0; k < 3; k++) begin
        pp_ll_r[k] <= (GL_W+XH_W)'(gcoef_r[GL_W-1:0]) * (GL_W+XH_W)'(x_r[k][XH_W-1:0]);
        pp_lh_r[k] <= (GL_W+XH_W)'(gcoef_r[GL_W-1:0]) * (GL_W+XH_W)'(x_r[k][X_W-1:XH_W]);
        pp_hl_r[k] <= (GH_W+XH_W)'(gcoef_r[GCOEF_W-1:GL_W])
                    * (GH_W+XH_W)'(x_r[k][XH_W-1:0]);
        pp_hh_r[k] <= (GH_W+XH_W)'(gcoef_r[GCOEF_W-1:GL_W])
                    * (GH_W+XH_W)'(x_r[k][X_W-1:XH_W]);
      end

      farg2_r <= farg1_r;
      wt2_r   <= wt1_r;
      neg2_r  <= neg1_r;
      g_r     <= g_nxt;
    end
  end

  // output register: sign, saturation, far-field zero
  out_item_t             out_item_nxt;
  out_item_t             out_item_r;
  logic [2:0][GRAD_W-1:0] grad_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (farg2_r || (g_r[k] == '0)) begin
        grad_nxt[k] = '0;
      end else if (neg2_r[k]) begin
        grad_nxt[k] = GRAD_W'(-g_r[k]);
      end else begin
        grad_nxt[k] = g_r[k][G_W-1] ? G_POS : g_r[k];
      end
    end
    out_item_nxt.weight = farg2_r ? '0 : WEIGHT_W'(wt2_r);
    out_item_nxt.grad_x = grad_nxt[0];
    out_item_nxt.grad_y = grad_nxt[1];
    out_item_nxt.grad_z = grad_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> bench/testbench.sv
// testbench: randomized check of sph_cubic_spline_kernel_core against a
// bit-exact kernel predictor held in a small scoreboard class.
// Depends on sphk_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import sphk_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int WATCHDOG    = 400000;
  localparam int DRAIN_WAIT  = 120;
  localparam int PHASE_PAIRS = 320;
  localparam logic [63:0] ONE_FX   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO_FX   = 64'd2 << FRAC_BITS;
  localparam logic [63:0] WT_MAX   = 64'h7F_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG  = 64'h80_0000_0000;
  // separations around the branch edges at the reset smoothing length
  localparam int EDGE_SEPS[10] = '{6553, 6554, 6555, 13107, 13108, 13109,
                                   3276, 8738, 1, 20000};

  // expected kernel values and the register copy they are computed from
  class kernel_scoreboard;
    logic [63:0] h_len, inv_h, norm_c, grad_c;
    out_item_t   pending[$];
    int          mismatches;
    int          strays;

    function new();
      h_len = 64'd6554;
      inv_h = 64'd655360;
      norm_c = 64'd5215189;
      grad_c = 64'd5215189000;
      mismatches = 0;
      strays = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SMOOTH_LEN: h_len = 64'(val[H_W-1:0]);
        CFG_INV_SMOOTH: inv_h = 64'(val[INV_H_W-1:0]);
        CFG_NORM_COEF:  norm_c = 64'(val[NORM_W-1:0]);
        CFG_GRAD_COEF:  grad_c = 64'(val[GCOEF_W-1:0]);
        default: ;
      endcase
    endfunction

    static function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (t * t <= v) res = t;
      end
      return res;
    endfunction

    static function logic [63:0] cube_fx(logic [63:0] t);
      logic [63:0] u;
      u = (t * t) >> FRAC_BITS;
      return (u * t) >> FRAC_BITS;
    endfunction

    static function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor(a*b / 2^F) on a full product, clamped at 2^39
    static function logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] pr;
      pr = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
      return pr > {64'd0, NEG_MAG} ? NEG_MAG : pr[63:0];
    endfunction

    static function logic [GRAD_W-1:0] signed_grad(logic [63:0] m, bit neg);
      if (m == 0) return '0;
      if (neg) return GRAD_W'(-(m > NEG_MAG ? NEG_MAG : m));
      return GRAD_W'(m > WT_MAX ? WT_MAX : m);
    endfunction

    function out_item_t kernel_of(in_item_t p);
      longint      dv[3];
      logic [63:0] ad[3];
      logic [63:0] r2, r, q, poly, wt, la, da, pv, m, g;
      longint      lin, diff;
      out_item_t   res;
      dv[0] = longint'(p.pos_a_x) - longint'(p.pos_b_x);
      dv[1] = longint'(p.pos_a_y) - longint'(p.pos_b_y);
      dv[2] = longint'(p.pos_a_z) - longint'(p.pos_b_z);
      r2 = 0;
      for (int i = 0; i < 3; i++) begin
        ad[i] = mag(dv[i]);
        r2 += ad[i] * ad[i];
      end
      r = floor_root(r2);
      q = (r * inv_h) >> FRAC_BITS;
      res = '0;
      if (q >= TWO_FX) return res;
      // inner branch subtracts the (1-q) cube
      if (q < ONE_FX) poly = cube_fx(TWO_FX - q) - 4 * cube_fx(ONE_FX - q);
      else poly = cube_fx(TWO_FX - q);
      wt = (norm_c * poly) >> FRAC_BITS;
      res.weight = WEIGHT_W'(wt > WT_MAX ? WT_MAX : wt);
      if (q < ONE_FX) begin
        lin = 3 * longint'(r) - 4 * longint'(h_len);
        la = mag(lin);
        for (int i = 0; i < 3; i++) begin
          m = (ad[i] * la) >> FRAC_BITS;
          g = scale_sat(grad_c, 3 * m);
          if (i == 0) res.grad_x = signed_grad(g, (dv[i] < 0) != (lin < 0));
          if (i == 1) res.grad_y = signed_grad(g, (dv[i] < 0) != (lin < 0));
          if (i == 2) res.grad_z = signed_grad(g, (dv[i] < 0) != (lin < 0));
        end
      end else if (r != 0) begin
        diff = longint'(r) - 2 * longint'(h_len);
        da = mag(diff);
        pv = (da * da) >> FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
          m = (ad[i] * pv) / r;
          g = scale_sat(grad_c, 3 * m);
          if (i == 0) res.grad_x = signed_grad(g, dv[i] > 0);
          if (i == 1) res.grad_y = signed_grad(g, dv[i] > 0);
          if (i == 2) res.grad_z = signed_grad(g, dv[i] > 0);
        end
      end
      return res;
    endfunction

    function void note_pair(in_item_t p);
      pending.push_back(kernel_of(p));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.weight !== want.weight || got.grad_x !== want.grad_x ||
          got.grad_y !== want.grad_y || got.grad_z !== want.grad_z) begin
        mismatches++;
        if (strays + mismatches <= 10) begin
          $display("mismatch: weight exp %h got %h", want.weight, got.weight);
          $display("  grad exp %h %h %h", want.grad_x, want.grad_y, want.grad_z);
          $display("  grad got %h %h %h", got.grad_x, got.grad_y, got.grad_z);
        end
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SMOOTH_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kernel_scoreboard sb = new();
  int  cycles = 0;
  int  stall_left = 0;
  bit  stall_quiet = 0;

  sph_cubic_spline_kernel_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
    .out_item, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #CLK_HALF clk = ~clk;

  // result check and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if (cycles > WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver backpressure: quiet stretches, short stalls and a few long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (cycles % 500 == 0) stall_quiet = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1;
      end else if (stall_quiet) begin
        out_stall <= 0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  out_stall <= 0;
          [70:94]: begin out_stall <= 1; stall_left = $urandom_range(0, 2); end
          default: begin out_stall <= 1; stall_left = $urandom_range(9, 39); end
        endcase
      end
    end
  end

  task automatic send_pair(in_item_t p);
    in_valid <= 1;
    in_item <= p;
    do @(posedge clk); while (in_stall);
    sb.note_pair(p);
  endtask

  // sender gap after an item, mostly none
  task automatic sender_gap();
    int n;
    case ($urandom_range(0, 99)) inside
      [0:59]:  n = 0;
      [60:94]: n = $urandom_range(1, 3);
      default: n = $urandom_range(10, 40);
    endcase
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic load_regs(logic [63:0] h, logic [63:0] inv, logic [63:0] nc,
                           logic [63:0] gc);
    drain();
    write_reg(CFG_SMOOTH_LEN, h);
    write_reg(CFG_INV_SMOOTH, inv);
    write_reg(CFG_NORM_COEF, nc);
    write_reg(CFG_GRAD_COEF, gc);
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] clamp_real(real x, logic [63:0] top);
    if (x >= real'(top)) return top;
    if (x < 1.0) return 64'd1;
    return 64'(longint'(x));
  endfunction

  // consistent register set for a smoothing length h
  task automatic load_physical(int h);
    real hr, c;
    hr = h / 65536.0;
    c = 1.0 / (4.0 * 3.14159265358979 * hr * hr * hr);
    load_regs(64'(h), clamp_real(4294967296.0 / h, 64'hFFFF_FFFF),
              clamp_real(c * 65536.0, 64'hFFFF_FFFF),
              clamp_real(c / (hr * hr * hr) * 65536.0, 64'h7F_FFFF_FFFF));
  endtask

  function automatic in_item_t pair_from(logic [19:0] ax, logic [19:0] ay,
                                         logic [19:0] az, logic [19:0] bx,
                                         logic [19:0] by, logic [19:0] bz);
    in_item_t p;
    p.pos_a_x = ax; p.pos_a_y = ay; p.pos_a_z = az;
    p.pos_b_x = bx; p.pos_b_y = by; p.pos_b_z = bz;
    return p;
  endfunction

  // mostly neighbors within about two smoothing lengths, some noise
  function automatic in_item_t random_pair();
    in_item_t p;
    int span, sel;
    logic [19:0] ax, ay, az;
    sel = $urandom_range(0, 99);
    ax = 20'($urandom); ay = 20'($urandom); az = 20'($urandom);
    span = int'(sb.h_len * 5 / 4);
    if (span > 524287) span = 524287;
    if (sel < 10) span = 3;
    if (sel >= 90)
      return pair_from(ax, ay, az, 20'($urandom), 20'($urandom), 20'($urandom));
    return pair_from(ax, ay, az,
                     ax - 20'($signed($urandom_range(0, 2 * span)) - span),
                     ay - 20'($signed($urandom_range(0, 2 * span)) - span),
                     az - 20'($signed($urandom_range(0, 2 * span)) - span));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_pair(random_pair());
      // one mid-phase hold-off until everything is back
      if (i == n / 2) drain();
      else sender_gap();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: coincident, extreme separations, branch edges at reset h
    send_pair('0);
    send_pair(pair_from(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000));
    send_pair(pair_from(20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    send_pair(pair_from(20'h7FFFF, '0, '0, 20'h80000, '0, '0));
    send_pair(pair_from(20'h12345, 20'hABCDE, 20'h55555, 20'h12345, 20'hABCDE, 20'h55555));
    foreach (EDGE_SEPS[k]) begin
      send_pair(pair_from(20'(EDGE_SEPS[k]), '0, '0, '0, '0, '0));
      send_pair(pair_from('0, '0, 20'(-EDGE_SEPS[k]), '0, '0, '0));
    end
    send_pair(pair_from('0, 20'd3000, '0, '0, 20'hFF000, '0));
    send_pair(pair_from(20'd2000, 20'd2000, 20'd2000, 20'hFF830, 20'hFF830, 20'hFF830));
    random_phase(PHASE_PAIRS);

    load_physical($urandom_range(3000, 40000));
    random_phase(PHASE_PAIRS);

    // all registers at their upper ends: saturation everywhere
    load_regs(64'h3FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h7F_FFFF_FFFF);
    send_pair(pair_from(20'd1, '0, '0, '0, '0, '0));
    random_phase(PHASE_PAIRS);

    // lower ends: q stays tiny, weights vanish
    load_regs(64'd1, 64'd1, 64'd0, 64'd0);
    random_phase(PHASE_PAIRS);

    load_physical($urandom_range(200, 2000));
    random_phase(PHASE_PAIRS);

    // registers with no relation to each other
    load_regs(64'($urandom_range(1, 262143)), 64'({$urandom} | 1), 64'($urandom),
              {$urandom, $urandom} & 64'h7F_FFFF_FFFF);
    random_phase(PHASE_PAIRS);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
